/* rtl/mrm_pkg.sv */
// shared types and constants for the modbus rtu master frame engine
// no dependencies
package mrm_pkg;

  // input command codes
  localparam logic [1:0] CMD_WRITE     = 2'd0;
  localparam logic [1:0] CMD_READ_IN   = 2'd1;
  localparam logic [1:0] CMD_READ_HOLD = 2'd2;
  localparam logic [1:0] CMD_RX_BYTE   = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FORMAT = 2'd1;
  localparam logic [1:0] STAT_CRC    = 2'd2;

  // modbus function codes
  localparam logic [7:0] FN_WRITE     = 8'h06;
  localparam logic [7:0] FN_READ_IN   = 8'h04;
  localparam logic [7:0] FN_READ_HOLD = 8'h03;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // holding register count limit
  localparam logic [6:0] MAX_REGS = 7'd125;

  // request queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef enum logic [3:0] {
    MODE_IDLE      = 4'b0001,
    MODE_WRITE     = 4'b0010,
    MODE_READ_IN   = 4'b0100,
    MODE_READ_HOLD = 4'b1000
  } mode_e;

  // classified entry handed from front to back
  typedef struct packed {
    logic        is_rx;
    mode_e       mode;
    logic [7:0]  id;
    logic [15:0] addr;
    logic [15:0] operand;
    logic [8:0]  exp_len;
    logic [7:0]  rx_byte;
  } q_entry_t;

endpackage

/* rtl/mrm_if.sv */
// request and result channel interfaces for the modbus rtu master frame engine
// no dependencies
interface mrm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  slave_id;
  logic [15:0] reg_addr;
  logic [15:0] reg_value;
  logic [6:0]  reg_count;
  logic [7:0]  rx_byte;

  modport source (output valid, command, slave_id, reg_addr, reg_value, reg_count, rx_byte,
                  input ready);
  modport sink (input valid, command, slave_id, reg_addr, reg_value, reg_count, rx_byte,
                output ready);
endinterface

interface mrm_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic [15:0] data_word;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, kind, tx_byte, data_word, status, last, input ready);
  modport sink (input valid, kind, tx_byte, data_word, status, last, output ready);
endinterface

/* rtl/mrm_front.sv */
// front end: accepts input items and classifies them into queue entries
// depends on mrm_pkg and mrm_if
module mrm_front #(
  parameter logic [6:0] MAX_REGS = mrm_pkg::MAX_REGS
) (
  mrm_req_if.sink             req_i,
  input  logic                full_i,
  output logic                push_o,
  output mrm_pkg::q_entry_t   entry_o
);

  logic [6:0] count_sat;

  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i;
  assign count_sat   = (req_i.reg_count > MAX_REGS) ? MAX_REGS : req_i.reg_count;

  always_comb begin
    entry_o.is_rx   = 1'b0;
    entry_o.mode    = mrm_pkg::MODE_IDLE;
    entry_o.id      = req_i.slave_id;
    entry_o.addr    = req_i.reg_addr;
    entry_o.operand = 16'h0000;
    entry_o.exp_len = 9'd0;
    entry_o.rx_byte = req_i.rx_byte;
    unique case (req_i.command)
      mrm_pkg::CMD_WRITE: begin
        entry_o.mode    = mrm_pkg::MODE_WRITE;
        entry_o.operand = req_i.reg_value;
        entry_o.exp_len = 9'd8;
      end
      mrm_pkg::CMD_READ_IN: begin
        entry_o.mode    = mrm_pkg::MODE_READ_IN;
        entry_o.operand = 16'h0001;
        entry_o.exp_len = 9'd7;
      end
      mrm_pkg::CMD_READ_HOLD: begin
        entry_o.mode    = mrm_pkg::MODE_READ_HOLD;
        entry_o.operand = {9'd0, count_sat};
        // header, two bytes per register, crc
        entry_o.exp_len = 9'd5 + {1'b0, count_sat, 1'b0};
      end
      mrm_pkg::CMD_RX_BYTE: begin
        entry_o.is_rx = 1'b1;
      end
      default: begin
        entry_o.is_rx = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/mrm_queue.sv */
// short fifo of classified entries between front and back
// depends on mrm_pkg
module mrm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mrm_pkg::q_entry_t entry_i,
  output logic              full_o,
  output logic              valid_o,
  output mrm_pkg::q_entry_t entry_o,
  input  logic              pop_i
);

  localparam int unsigned CW = $clog2(mrm_pkg::QDEPTH + 1);

  mrm_pkg::q_entry_t            mem_q [mrm_pkg::QDEPTH];
  logic [mrm_pkg::QAW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [mrm_pkg::QAW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]                cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(mrm_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == mrm_pkg::QAW'(mrm_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == mrm_pkg::QAW'(mrm_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

/* rtl/mrm_back.sv */
// back end: sends request frames, checks response bytes, drives the result register
// depends on mrm_pkg and mrm_if
module mrm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  mrm_pkg::q_entry_t q_entry_i,
  output logic              q_pop_o,
  mrm_res_if.source         res_o
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] data_word;
    logic [1:0]  status;
    logic        last;
  } res_word_t;

  function automatic logic [15:0] crc_upd(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ mrm_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // control state
  mrm_pkg::mode_e mode_q, mode_d;
  logic           tx_active_q, tx_active_d;
  logic [2:0]     tx_idx_q, tx_idx_d;
  logic [8:0]     rx_idx_q, rx_idx_d;
  logic [8:0]     exp_len_q, exp_len_d;
  logic [15:0]    rx_crc_q, rx_crc_d;
  logic [7:0]     hold_q, hold_d;
  logic [1:0]     err_q, err_d;
  logic           res_valid_q, res_valid_d;

  // request fields, tx_crc ends up as the request crc
  logic [7:0]     id_q, id_d;
  logic [15:0]    addr_q, addr_d;
  logic [15:0]    operand_q, operand_d;
  logic [15:0]    tx_crc_q, tx_crc_d;
  res_word_t      res_q, res_d;

  logic           can_out;
  logic [7:0]     fn_code;
  logic [7:0]     req_bytes [8];
  logic [7:0]     rx_b;
  logic [8:0]     crc_pos;
  logic [7:0]     want_cnt;
  logic [1:0]     err_new;
  logic [8:0]     idx_next;

  assign can_out = !res_valid_q || res_o.ready;
  assign rx_b    = q_entry_i.rx_byte;
  assign crc_pos = exp_len_q - 9'd2;

  always_comb begin
    unique case (mode_q)
      mrm_pkg::MODE_WRITE:     fn_code = mrm_pkg::FN_WRITE;
      mrm_pkg::MODE_READ_IN:   fn_code = mrm_pkg::FN_READ_IN;
      mrm_pkg::MODE_READ_HOLD: fn_code = mrm_pkg::FN_READ_HOLD;
      default:                 fn_code = 8'h00;
    endcase
  end

  assign req_bytes[0] = id_q;
  assign req_bytes[1] = fn_code;
  assign req_bytes[2] = addr_q[15:8];
  assign req_bytes[3] = addr_q[7:0];
  assign req_bytes[4] = operand_q[15:8];
  assign req_bytes[5] = operand_q[7:0];
  assign req_bytes[6] = tx_crc_q[7:0];
  assign req_bytes[7] = tx_crc_q[15:8];

  assign want_cnt = (mode_q == mrm_pkg::MODE_READ_IN) ? 8'd2 : {operand_q[6:0], 1'b0};

  always_comb begin
    mode_d      = mode_q;
    tx_active_d = tx_active_q;
    tx_idx_d    = tx_idx_q;
    rx_idx_d    = rx_idx_q;
    exp_len_d   = exp_len_q;
    rx_crc_d    = rx_crc_q;
    hold_d      = hold_q;
    err_d       = err_q;
    id_d        = id_q;
    addr_d      = addr_q;
    operand_d   = operand_q;
    tx_crc_d    = tx_crc_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_o.ready;
    q_pop_o     = 1'b0;
    err_new     = 2'b00;
    idx_next    = rx_idx_q + 9'd1;

    if (tx_active_q) begin
      if (can_out) begin
        res_valid_d = 1'b1;
        res_d       = '{kind: mrm_pkg::KIND_TX, tx_byte: req_bytes[tx_idx_q], data_word: 16'h0,
                        status: mrm_pkg::STAT_OK, last: (tx_idx_q == 3'd7)};
        if (tx_idx_q < 3'd6) begin
          tx_crc_d = crc_upd(tx_crc_q, req_bytes[tx_idx_q]);
        end
        tx_idx_d = tx_idx_q + 3'd1;
        if (tx_idx_q == 3'd7) begin
          tx_active_d = 1'b0;
        end
      end
    end else if (q_valid_i && can_out) begin
      q_pop_o = 1'b1;
      if (!q_entry_i.is_rx) begin
        // new request drops any pending exchange; first frame byte goes out now
        mode_d      = q_entry_i.mode;
        id_d        = q_entry_i.id;
        addr_d      = q_entry_i.addr;
        operand_d   = q_entry_i.operand;
        exp_len_d   = q_entry_i.exp_len;
        tx_crc_d    = crc_upd(mrm_pkg::CRC_INIT, q_entry_i.id);
        tx_idx_d    = 3'd1;
        tx_active_d = 1'b1;
        rx_idx_d    = 9'd0;
        rx_crc_d    = mrm_pkg::CRC_INIT;
        hold_d      = 8'h00;
        err_d       = 2'b00;
        res_valid_d = 1'b1;
        res_d       = '{kind: mrm_pkg::KIND_TX, tx_byte: q_entry_i.id, data_word: 16'h0,
                        status: mrm_pkg::STAT_OK, last: 1'b0};
      end else if (mode_q != mrm_pkg::MODE_IDLE) begin
        if (mode_q == mrm_pkg::MODE_WRITE) begin
          // echo check, crc bytes included
          if (rx_b != req_bytes[rx_idx_q[2:0]]) begin
            err_new[0] = 1'b1;
          end
        end else begin
          priority if (rx_idx_q == 9'd0) begin
            err_new[0] = (rx_b != id_q);
          end else if (rx_idx_q == 9'd1) begin
            err_new[0] = (rx_b != fn_code);
          end else if (rx_idx_q == 9'd2) begin
            err_new[0] = (rx_b != want_cnt);
          end else if (rx_idx_q < crc_pos) begin
            if (rx_idx_q[0]) begin
              hold_d = rx_b;
            end else if (!err_q[0]) begin
              res_valid_d = 1'b1;
              res_d       = '{kind: mrm_pkg::KIND_WORD, tx_byte: 8'h00,
                              data_word: {hold_q, rx_b}, status: mrm_pkg::STAT_OK,
                              last: 1'b0};
            end
          end else begin
            err_new[0] = 1'b0;
          end
          priority if (rx_idx_q < crc_pos) begin
            rx_crc_d = crc_upd(rx_crc_q, rx_b);
          end else if (rx_idx_q == crc_pos) begin
            err_new[1] = (rx_b != rx_crc_q[7:0]);
          end else begin
            err_new[1] = (rx_b != rx_crc_q[15:8]);
          end
        end
        err_d    = err_q | err_new;
        rx_idx_d = idx_next;
        if (idx_next >= exp_len_q) begin
          res_valid_d = 1'b1;
          res_d       = '{kind: mrm_pkg::KIND_STATUS, tx_byte: 8'h00, data_word: 16'h0,
                          status: err_d[0] ? mrm_pkg::STAT_FORMAT
                                : (err_d[1] ? mrm_pkg::STAT_CRC : mrm_pkg::STAT_OK),
                          last: 1'b1};
          mode_d   = mrm_pkg::MODE_IDLE;
          rx_idx_d = 9'd0;
          rx_crc_d = mrm_pkg::CRC_INIT;
          hold_d   = 8'h00;
          err_d    = 2'b00;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= mrm_pkg::MODE_IDLE;
      tx_active_q <= 1'b0;
      tx_idx_q    <= 3'd0;
      rx_idx_q    <= 9'd0;
      exp_len_q   <= 9'd0;
      rx_crc_q    <= mrm_pkg::CRC_INIT;
      hold_q      <= 8'h00;
      err_q       <= 2'b00;
      res_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      tx_active_q <= tx_active_d;
      tx_idx_q    <= tx_idx_d;
      rx_idx_q    <= rx_idx_d;
      exp_len_q   <= exp_len_d;
      rx_crc_q    <= rx_crc_d;
      hold_q      <= hold_d;
      err_q       <= err_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q      <= id_d;
    addr_q    <= addr_d;
    operand_q <= operand_d;
    tx_crc_q  <= tx_crc_d;
    res_q     <= res_d;
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.kind      = res_q.kind;
  assign res_o.tx_byte   = res_q.tx_byte;
  assign res_o.data_word = res_q.data_word;
  assign res_o.status    = res_q.status;
  assign res_o.last      = res_q.last;

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.kind == mrm_pkg::KIND_STATUS) |-> res_q.last)
    else $error("status result without last");

  a_tx_needs_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_active_q |-> (mode_q != mrm_pkg::MODE_IDLE))
    else $error("frame transmit while idle");

  a_status_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (can_out && res_valid_d && res_d.kind == mrm_pkg::KIND_STATUS)
      |=> (mode_q == mrm_pkg::MODE_IDLE && !tx_active_q))
    else $error("engine not idle after status");

  a_rx_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != mrm_pkg::MODE_IDLE) |-> (rx_idx_q < exp_len_q))
    else $error("response index beyond expected length");

endmodule

/* rtl/modbus_rtu_master_frame_engine.sv */
// modbus rtu master frame engine: front classifier, request queue and back sequencer
// depends on mrm_pkg, mrm_if, mrm_front, mrm_queue and mrm_back
//
// req_i carries commands: write register, read input register, read holding
// registers (each builds an 8-byte request frame with crc-16, low byte first)
// and received response bytes. res_o returns transmit bytes, big-endian data
// words and one final status (ok, format error, crc error); last marks the status and the final transmit byte.
// A request yields eight transmit results from the back sequencer; a response
// byte yields at most one result. An accepted item is written into the queue
// and then into the result register before its first result is offered on res_o.
// The back sequencer's one-item-per-cycle step sets the rate: one result per
// cycle while res_o is ready; the two-entry queue takes up to two further
// requests while a frame is being sent or the result register waits.
// Received bytes while no exchange is open are dropped; a new request drops
// an open exchange. When res_o stalls the result register holds and the
// queue fills, then req_i.ready falls.
// Reset is asynchronous and active low; it empties the queue and returns the
// engine to idle with no result pending.
module modbus_rtu_master_frame_engine #(
  parameter logic [6:0] MAX_REGS = mrm_pkg::MAX_REGS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mrm_req_if.sink   req_i,
  mrm_res_if.source res_o
);

  logic              push;
  logic              full;
  logic              q_valid;
  logic              q_pop;
  mrm_pkg::q_entry_t push_entry;
  mrm_pkg::q_entry_t q_entry;

  mrm_front #(
    .MAX_REGS (MAX_REGS)
  ) u_front (
    .req_i   (req_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  mrm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .valid_o (q_valid),
    .entry_o (q_entry),
    .pop_i   (q_pop)
  );

  mrm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule

/* bench/modbus_rtu_master_frame_engine_test.sv */
`timescale 1ns / 1ps
// self-checking bench for modbus_rtu_master_frame_engine: request frames, echo and read
// responses with faults, checked in order against an engine predictor in this file
// depends on mrm_pkg, mrm_if and the engine rtl
module modbus_rtu_master_frame_engine_test;

  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_ITEMS  = 90;
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef logic [7:0][7:0] frame_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] data_word;
    logic [1:0]  status;
    logic        last;
  } result_t;

  logic clk;
  logic rst_n;

  mrm_req_if req_bus ();
  mrm_res_if res_bus ();

  modbus_rtu_master_frame_engine uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_bus),
    .res_o (res_bus)
  );

  result_t pending_results[$];
  int      errors     = 0;
  int      items_sent = 0;
  int      stall_seq  = 0;
  bit      calm       = 1'b0;

  // engine state as predicted
  mrm_pkg::mode_e eng_mode    = mrm_pkg::MODE_IDLE;
  frame_t         eng_frame   = '0;
  logic [8:0]     eng_idx     = '0;
  logic [8:0]     eng_len     = '0;
  logic [15:0]    eng_crc     = mrm_pkg::CRC_INIT;
  logic [7:0]     eng_hold    = '0;
  logic           eng_fmt_err = 1'b0;
  logic           eng_crc_err = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ mrm_pkg::CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic frame_t build_frame(input logic [1:0] cmd, input logic [7:0] id,
                                         input logic [15:0] addr, input logic [15:0] value,
                                         input logic [6:0] count);
    frame_t      f;
    logic [7:0]  fn;
    logic [15:0] operand;
    logic [15:0] crc;
    case (cmd)
      mrm_pkg::CMD_WRITE: begin
        fn      = mrm_pkg::FN_WRITE;
        operand = value;
      end
      mrm_pkg::CMD_READ_IN: begin
        fn      = mrm_pkg::FN_READ_IN;
        operand = 16'd1;
      end
      default: begin
        fn      = mrm_pkg::FN_READ_HOLD;
        operand = {9'd0, (count > mrm_pkg::MAX_REGS) ? mrm_pkg::MAX_REGS : count};
      end
    endcase
    f[0] = id;
    f[1] = fn;
    f[2] = addr[15:8];
    f[3] = addr[7:0];
    f[4] = operand[15:8];
    f[5] = operand[7:0];
    crc  = mrm_pkg::CRC_INIT;
    for (int i = 0; i < 6; i++) crc = crc16_byte(crc, f[i]);
    f[6] = crc[7:0];
    f[7] = crc[15:8];
    return f;
  endfunction

  task automatic push_result(input logic [1:0] kind, input logic [7:0] tx,
                             input logic [15:0] word, input logic [1:0] st, input logic last);
    result_t r;
    r = '{kind: kind, tx_byte: tx, data_word: word, status: st, last: last};
    pending_results.push_back(r);
  endtask

  task automatic predict_engine(input logic [1:0] cmd, input logic [7:0] id,
                                input logic [15:0] addr, input logic [15:0] value,
                                input logic [6:0] count, input logic [7:0] b);
    logic [8:0] crc_pos;
    logic [7:0] want;
    if (cmd != mrm_pkg::CMD_RX_BYTE) begin
      eng_frame = build_frame(cmd, id, addr, value, count);
      case (cmd)
        mrm_pkg::CMD_WRITE: begin
          eng_mode = mrm_pkg::MODE_WRITE;
          eng_len  = 9'd8;
        end
        mrm_pkg::CMD_READ_IN: begin
          eng_mode = mrm_pkg::MODE_READ_IN;
          eng_len  = 9'd7;
        end
        default: begin
          eng_mode = mrm_pkg::MODE_READ_HOLD;
          eng_len  = 9'd5 + {eng_frame[5], 1'b0};
        end
      endcase
      eng_idx     = '0;
      eng_crc     = mrm_pkg::CRC_INIT;
      eng_hold    = '0;
      eng_fmt_err = 1'b0;
      eng_crc_err = 1'b0;
      for (int i = 0; i < 8; i++)
        push_result(mrm_pkg::KIND_TX, eng_frame[i], 16'h0, mrm_pkg::STAT_OK, i == 7);
    end else if (eng_mode != mrm_pkg::MODE_IDLE) begin
      if (eng_mode == mrm_pkg::MODE_WRITE) begin
        if (eng_idx < 9'd8 && b != eng_frame[eng_idx[2:0]]) eng_fmt_err = 1'b1;
      end else begin
        crc_pos = eng_len - 9'd2;
        if (eng_idx == 9'd0) begin
          if (b != eng_frame[0]) eng_fmt_err = 1'b1;
        end else if (eng_idx == 9'd1) begin
          if (b != eng_frame[1]) eng_fmt_err = 1'b1;
        end else if (eng_idx == 9'd2) begin
          want = (eng_mode == mrm_pkg::MODE_READ_IN) ? 8'd2 : {eng_frame[5][6:0], 1'b0};
          if (b != want) eng_fmt_err = 1'b1;
        end else if (eng_idx < crc_pos) begin
          // data bytes start at index 3: odd index is the high byte
          if (eng_idx[0]) eng_hold = b;
          else if (!eng_fmt_err)
            push_result(mrm_pkg::KIND_WORD, 8'h0, {eng_hold, b}, mrm_pkg::STAT_OK, 1'b0);
        end
        if (eng_idx < crc_pos) eng_crc = crc16_byte(eng_crc, b);
        else if (eng_idx == crc_pos) begin
          if (b != eng_crc[7:0]) eng_crc_err = 1'b1;
        end else if (b != eng_crc[15:8]) eng_crc_err = 1'b1;
      end
      eng_idx = eng_idx + 9'd1;
      if (eng_idx >= eng_len) begin
        push_result(mrm_pkg::KIND_STATUS, 8'h0, 16'h0,
                    eng_fmt_err ? mrm_pkg::STAT_FORMAT
                                : (eng_crc_err ? mrm_pkg::STAT_CRC : mrm_pkg::STAT_OK),
                    1'b1);
        eng_mode    = mrm_pkg::MODE_IDLE;
        eng_idx     = '0;
        eng_crc     = mrm_pkg::CRC_INIT;
        eng_hold    = '0;
        eng_fmt_err = 1'b0;
        eng_crc_err = 1'b0;
      end
    end
  endtask

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    errors++;
    $display("mismatch %0d at %0t: %s got 0x%0h want 0x%0h",
             errors, $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && req_bus.valid && req_bus.ready)
      predict_engine(req_bus.command, req_bus.slave_id, req_bus.reg_addr, req_bus.reg_value,
                     req_bus.reg_count, req_bus.rx_byte);
  end

  always @(posedge clk) begin : check_results
    result_t want_r;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (pending_results.size() == 0) begin
        report("result with nothing pending, kind", 16'(res_bus.kind), 16'h0);
      end else begin
        want_r = pending_results.pop_front();
        if (res_bus.kind !== want_r.kind)
          report("kind", 16'(res_bus.kind), 16'(want_r.kind));
        if (res_bus.tx_byte !== want_r.tx_byte)
          report("tx_byte", 16'(res_bus.tx_byte), 16'(want_r.tx_byte));
        if (res_bus.data_word !== want_r.data_word)
          report("data_word", res_bus.data_word, want_r.data_word);
        if (res_bus.status !== want_r.status)
          report("status", 16'(res_bus.status), 16'(want_r.status));
        if (res_bus.last !== want_r.last)
          report("last", 16'(res_bus.last), 16'(want_r.last));
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side: random ready pattern, plus a long hold-off on each stall_seq bump
  initial begin : drive_ready
    int seen;
    int stall_left;
    int low_left;
    int high_left;
    seen       = 0;
    stall_left = 0;
    low_left   = 0;
    high_left  = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_seq != seen) begin
        seen       = stall_seq;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else if (low_left > 0) begin
        low_left--;
        res_bus.ready <= 1'b0;
      end else if (high_left > 0) begin
        high_left--;
        res_bus.ready <= 1'b1;
      end else begin
        high_left = calm ? 50 : $urandom_range(0, 12);
        low_left  = pick_gap();
        res_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] id, input logic [15:0] addr,
                           input logic [15:0] value, input logic [6:0] count,
                           input logic [7:0] b, input bit counted);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid     <= 1'b1;
    req_bus.command   <= cmd;
    req_bus.slave_id  <= id;
    req_bus.reg_addr  <= addr;
    req_bus.reg_value <= value;
    req_bus.reg_count <= count;
    req_bus.rx_byte   <= b;
    do @(posedge clk); while (!req_bus.ready);
    if (counted) items_sent++;
  endtask

  // the other request fields carry noise on a received byte
  task automatic send_rx(input logic [7:0] b, input bit counted);
    send_item(mrm_pkg::CMD_RX_BYTE, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)), b, counted);
  endtask

  // one request and its response; fault_pos < 0 leaves it clean, cut_len < 0 sends it whole
  task automatic run_exchange(input logic [1:0] cmd, input logic [7:0] id,
                              input logic [15:0] addr, input logic [15:0] value,
                              input logic [6:0] count, input int fault_pos,
                              input logic [7:0] fault_xor, input int cut_len);
    frame_t      f;
    logic [7:0]  resp[$];
    logic [15:0] crc;
    int          n_words;
    int          stop;
    f = build_frame(cmd, id, addr, value, count);
    send_item(cmd, id, addr, value, count, 8'($urandom_range(0, 255)), 1'b1);
    if (cmd == mrm_pkg::CMD_WRITE) begin
      for (int i = 0; i < 8; i++) resp.push_back(f[i]);
    end else begin
      n_words = (cmd == mrm_pkg::CMD_READ_IN) ? 1 : int'(f[5]);
      resp.push_back(f[0]);
      resp.push_back(f[1]);
      resp.push_back(8'(2 * n_words));
      for (int i = 0; i < 2 * n_words; i++) resp.push_back(8'($urandom_range(0, 255)));
      crc = mrm_pkg::CRC_INIT;
      foreach (resp[j]) crc = crc16_byte(crc, resp[j]);
      resp.push_back(crc[7:0]);
      resp.push_back(crc[15:8]);
    end
    // corrupting after the crc is built: a header fault also breaks the crc
    if (fault_pos >= 0 && fault_pos < resp.size()) resp[fault_pos] = resp[fault_pos] ^ fault_xor;
    stop = (cut_len >= 0 && cut_len < resp.size()) ? cut_len : resp.size();
    for (int i = 0; i < stop; i++) send_rx(resp[i], 1'b1);
  endtask

  task automatic random_exchange();
    logic [1:0] cmd;
    logic [6:0] count;
    int         r;
    int         len;
    int         fault_pos;
    int         cut_len;
    logic [7:0] fault_xor;
    r = $urandom_range(0, 99);
    cmd = (r < 35) ? mrm_pkg::CMD_WRITE
                   : ((r < 65) ? mrm_pkg::CMD_READ_IN : mrm_pkg::CMD_READ_HOLD);
    r = $urandom_range(0, 99);
    if (cmd != mrm_pkg::CMD_READ_HOLD) count = 7'($urandom_range(0, 127));
    else if (r < 4) count = 7'($urandom_range(125, 127));
    else if (r < 15) count = 7'd0;
    else count = 7'($urandom_range(1, 4));
    if (cmd == mrm_pkg::CMD_WRITE) len = 8;
    else if (cmd == mrm_pkg::CMD_READ_IN) len = 7;
    else len = 5 + 2 * int'((count > mrm_pkg::MAX_REGS) ? mrm_pkg::MAX_REGS : count);
    fault_pos = -1;
    fault_xor = 8'h00;
    cut_len   = -1;
    r = $urandom_range(0, 99);
    if (r >= 95) begin
      // exception style reply: function code with the top bit set
      fault_pos = 1;
      fault_xor = 8'h80;
    end else if (r >= 85) begin
      cut_len = $urandom_range(0, len - 1);
    end else if (r >= 65) begin
      fault_pos = $urandom_range(0, len - 1);
      fault_xor = 8'($urandom_range(1, 255));
    end
    run_exchange(cmd, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), count, fault_pos, fault_xor, cut_len);
  endtask

  // waits for the next clock edge first so that the predictor has seen the last accepted request
  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_idle_bytes();
    send_rx(8'h00, 1'b0);
    send_rx(8'hFF, 1'b0);
    wait_idle();
  endtask

  task automatic test_write_echo();
    run_exchange(mrm_pkg::CMD_WRITE, 8'h00, 16'h0000, 16'h0000, 7'd0, -1, 8'h00, -1);
    // bad crc byte in a write echo still counts as a format fault
    run_exchange(mrm_pkg::CMD_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF, 7'h7F, 7, 8'h01, -1);
    wait_idle();
  endtask

  task automatic test_read_input();
    run_exchange(mrm_pkg::CMD_READ_IN, 8'h11, 16'h1234, 16'h5678, 7'd1, 6, 8'hFF, -1);
    run_exchange(mrm_pkg::CMD_READ_IN, 8'h5A, 16'hA55A, 16'h0000, 7'd1, 1, 8'h80, -1);
    run_exchange(mrm_pkg::CMD_READ_IN, 8'hA5, 16'h00FF, 16'hFF00, 7'd64, -1, 8'h00, -1);
    wait_idle();
  endtask

  task automatic test_read_hold_edges();
    run_exchange(mrm_pkg::CMD_READ_HOLD, 8'h01, 16'h0010, 16'h0000, 7'd0, -1, 8'h00, -1);
    // wrong byte count: no words for the rest of the reply
    run_exchange(mrm_pkg::CMD_READ_HOLD, 8'h02, 16'h0020, 16'h0000, 7'd2, 2, 8'h02, -1);
    // count saturates, then a new request drops the open reply
    run_exchange(mrm_pkg::CMD_READ_HOLD, 8'h03, 16'hFFFF, 16'h0000, 7'd127, -1, 8'h00, 3);
    run_exchange(mrm_pkg::CMD_WRITE, 8'h7E, 16'h8001, 16'h7FFE, 7'd5, -1, 8'h00, -1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    stall_seq++;
    run_exchange(mrm_pkg::CMD_READ_HOLD, 8'($urandom_range(0, 255)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 7'd4, -1, 8'h00, -1);
    wait_idle();
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    repeat (4) random_exchange();
    wait_idle();
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    int target;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) send_rx(8'($urandom_range(0, 255)), 1'b0);
      else random_exchange();
    end
    wait_idle();
  endtask

  initial begin
    rst_n             <= 1'b0;
    req_bus.valid     <= 1'b0;
    req_bus.command   <= mrm_pkg::CMD_RX_BYTE;
    req_bus.slave_id  <= '0;
    req_bus.reg_addr  <= '0;
    req_bus.reg_value <= '0;
    req_bus.reg_count <= '0;
    req_bus.rx_byte   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_bytes();
    test_write_echo();
    test_read_input();
    test_read_hold_edges();
    test_backpressure();
    test_back_to_back();
    test_random_traffic();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report("results never returned, count", 16'(pending_results.size()), 16'h0);
    if (errors == 0) begin
      $display("** modbus_rtu_master_frame_engine: PASSED **");
    end else begin
      $display("** modbus_rtu_master_frame_engine: FAILED **");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("** modbus_rtu_master_frame_engine: FAILED **");
    $finish;
  end

endmodule
